### rtl/lr_pkg.sv
// lr_pkg: shared constants and codes for the line rasterizer.
// No dependencies; used by the channel interfaces and line_rasterizer.
package lr_pkg;

    localparam int FRAME_W_BITS = 13;
    localparam int ADDR_BITS    = 24;
    localparam int COLOR_BITS   = 8;

    localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET = 13'd1024;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

### rtl/lr_ifs.sv
// Valid/ready channel interfaces of the line rasterizer: line commands,
// pixel results and the frame width write channel. Depends on lr_pkg.

// line command channel
interface lr_line_if #(
    parameter int COORD_BITS = 12
);
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [COORD_BITS-1:0]           x_start;
    logic [COORD_BITS-1:0]           y_start;
    logic [COORD_BITS-1:0]           x_end;
    logic [COORD_BITS-1:0]           y_end;
    logic [lr_pkg::COLOR_BITS-1:0]   color;

    modport source (output valid, cmd, x_start, y_start, x_end, y_end, color,
                    input ready);
    modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, color,
                    output ready);
endinterface

// pixel result channel
interface lr_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                            valid;
    logic                            ready;
    logic                            pix_valid;
    logic [COORD_BITS-1:0]           pix_col;
    logic [COORD_BITS-1:0]           pix_row;
    logic [lr_pkg::ADDR_BITS-1:0]    pix_addr;
    logic [lr_pkg::COLOR_BITS-1:0]   pix_value;
    logic                            last_pixel;
    logic                            out_of_frame;

    modport source (output valid, pix_valid, pix_col, pix_row, pix_addr, pix_value,
                           last_pixel, out_of_frame,
                    input ready);
    modport sink   (input valid, pix_valid, pix_col, pix_row, pix_addr, pix_value,
                          last_pixel, out_of_frame,
                    output ready);
endinterface

// frame width write channel
interface lr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lr_pkg::FRAME_W_BITS-1:0] frame_width;

    modport source (output valid, frame_width, input ready);
    modport sink   (input valid, frame_width, output ready);
endinterface

### rtl/line_rasterizer.sv
// line_rasterizer: Bresenham line generator, one pixel result per command.
// Result path: middle register (line step), then output register (address).
// Throughput: one command per cycle unless o_pix.ready stalls the output; the rate
// is set by the one-step-per-cycle update of the line state and the registered
// row*width address multiply. Reset (i_rst_n low at a clock edge): no active line,
// pipeline empty, frame width back to 1024. Depends on lr_pkg and lr_ifs.
module line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lr_cfg_if.sink    i_cfg,
    lr_line_if.sink   i_line,
    lr_pix_if.source  o_pix
);

    localparam int ERR_W = COORD_BITS + 3;
    localparam int SUM_W = (COORD_BITS + 14 > lr_pkg::ADDR_BITS) ?
                           COORD_BITS + 14 : lr_pkg::ADDR_BITS;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic                          pix_valid;
        t_coord                        col;
        t_coord                        row;
        logic [lr_pkg::COLOR_BITS-1:0] color;
        logic                          last;
    } t_mid;

    typedef struct packed {
        logic                          pix_valid;
        t_coord                        col;
        t_coord                        row;
        logic [lr_pkg::ADDR_BITS-1:0]  addr;
        logic [lr_pkg::COLOR_BITS-1:0] color;
        logic                          last;
        logic                          oof;
    } t_res;

    // line state
    t_coord                        r_cur_major, n_cur_major;
    t_coord                        r_cur_minor, n_cur_minor;
    t_coord                        r_major_limit, n_major_limit;
    logic signed [ERR_W-1:0]       r_err, n_err;
    t_coord                        r_dmaj, n_dmaj;
    t_coord                        r_dmin, n_dmin;
    logic                          r_minor_down, n_minor_down;
    logic                          r_swapped, n_swapped;
    logic                          r_line_active, n_line_active;
    logic [lr_pkg::COLOR_BITS-1:0] r_color, n_color;

    logic [lr_pkg::FRAME_W_BITS-1:0] r_frame_width;

    // pipeline registers
    t_mid r_mid, n_mid;
    logic r_mid_vld;
    t_res r_out, n_out;
    logic r_out_vld;

    logic in_acc, out_adv;

    // setup terms
    t_coord                  adx, ady, sa1, sb1, sa2, sb2, a_lo, a_hi, b_lo, b_hi;
    t_coord                  s_dmaj, s_dmin;
    logic                    x_gt, y_gt, steep, reorder;
    logic signed [ERR_W-1:0] s_err;

    // working set for the current pixel
    t_coord                  w_major, w_minor, w_limit, w_dmaj, w_dmin;
    logic signed [ERR_W-1:0] w_err, w_2min, w_2maj;
    logic                    w_down, w_swapped, w_last, do_emit;
    logic [lr_pkg::COLOR_BITS-1:0] w_color;

    logic [SUM_W-1:0] sum_addr;

    // handshake: the output register frees the middle stage
    assign out_adv     = !r_out_vld || o_pix.ready;
    assign i_line.ready = !r_mid_vld || out_adv;
    assign in_acc      = i_line.valid && i_line.ready;
    assign i_cfg.ready = 1'b1;

    // line setup from the endpoints
    always_comb begin
        x_gt    = i_line.x_start > i_line.x_end;
        y_gt    = i_line.y_start > i_line.y_end;
        adx     = x_gt ? i_line.x_start - i_line.x_end : i_line.x_end - i_line.x_start;
        ady     = y_gt ? i_line.y_start - i_line.y_end : i_line.y_end - i_line.y_start;
        steep   = ady > adx;
        sa1     = steep ? i_line.y_start : i_line.x_start;
        sb1     = steep ? i_line.x_start : i_line.y_start;
        sa2     = steep ? i_line.y_end   : i_line.x_end;
        sb2     = steep ? i_line.x_end   : i_line.y_end;
        reorder = steep ? y_gt : x_gt;
        a_lo    = reorder ? sa2 : sa1;
        a_hi    = reorder ? sa1 : sa2;
        b_lo    = reorder ? sb2 : sb1;
        b_hi    = reorder ? sb1 : sb2;
        s_dmaj  = steep ? ady : adx;
        s_dmin  = steep ? adx : ady;
        s_err   = $signed({2'b00, s_dmin, 1'b0}) - $signed({3'b000, s_dmaj});
    end

    // pick setup or stored state, emit the pixel and advance one step unless it was the last
    always_comb begin
        do_emit   = (i_line.cmd == lr_pkg::CMD_START) || r_line_active;
        if (i_line.cmd == lr_pkg::CMD_START) begin
            w_major   = a_lo;
            w_minor   = b_lo;
            w_limit   = a_hi;
            w_dmaj    = s_dmaj;
            w_dmin    = s_dmin;
            w_err     = s_err;
            w_down    = b_lo >= b_hi;
            w_swapped = steep;
            w_color   = i_line.color;
        end else begin
            w_major   = r_cur_major;
            w_minor   = r_cur_minor;
            w_limit   = r_major_limit;
            w_dmaj    = r_dmaj;
            w_dmin    = r_dmin;
            w_err     = r_err;
            w_down    = r_minor_down;
            w_swapped = r_swapped;
            w_color   = r_color;
        end
        w_last = w_major == w_limit;
        w_2min = $signed({2'b00, w_dmin, 1'b0});
        w_2maj = $signed({2'b00, w_dmaj, 1'b0});

        n_cur_major   = w_major;
        n_cur_minor   = w_minor;
        n_major_limit = w_limit;
        n_dmaj        = w_dmaj;
        n_dmin        = w_dmin;
        n_err         = w_err;
        n_minor_down  = w_down;
        n_swapped     = w_swapped;
        n_color       = w_color;
        n_line_active = r_line_active;

        if (do_emit) begin
            if (w_last) begin
                n_line_active = 1'b0;
            end else begin
                n_line_active = 1'b1;
                n_cur_major   = w_major + t_coord'(1);
                if (w_err < 0) begin
                    n_err = w_err + w_2min;
                end else begin
                    n_err       = w_err + w_2min - w_2maj;
                    n_cur_minor = w_down ? w_minor - t_coord'(1) : w_minor + t_coord'(1);
                end
            end
        end

        // step without a line gives an all-zero result
        n_mid.pix_valid = do_emit;
        n_mid.col       = do_emit ? (w_swapped ? w_minor : w_major) : '0;
        n_mid.row       = do_emit ? (w_swapped ? w_major : w_minor) : '0;
        n_mid.color     = do_emit ? w_color : '0;
        n_mid.last      = do_emit && w_last;
    end

    // address and frame compare
    always_comb begin
        sum_addr = SUM_W'(r_mid.row) * SUM_W'(r_frame_width) + SUM_W'(r_mid.col);
        n_out.pix_valid = r_mid.pix_valid;
        n_out.col       = r_mid.col;
        n_out.row       = r_mid.row;
        n_out.addr      = sum_addr[lr_pkg::ADDR_BITS-1:0];
        n_out.color     = r_mid.color;
        n_out.last      = r_mid.last;
        n_out.oof       = r_mid.pix_valid && (SUM_W'(r_mid.col) >= SUM_W'(r_frame_width));
    end

    // state, config and pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_cur_major   <= '0;
            r_cur_minor   <= '0;
            r_major_limit <= '0;
            r_err         <= '0;
            r_dmaj        <= '0;
            r_dmin        <= '0;
            r_minor_down  <= 1'b0;
            r_swapped     <= 1'b0;
            r_color       <= '0;
            r_frame_width <= lr_pkg::FRAME_W_RESET;
            r_mid_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_frame_width <= i_cfg.frame_width;
            end
            if (in_acc) begin
                r_line_active <= n_line_active;
                r_cur_major   <= n_cur_major;
                r_cur_minor   <= n_cur_minor;
                r_major_limit <= n_major_limit;
                r_err         <= n_err;
                r_dmaj        <= n_dmaj;
                r_dmin        <= n_dmin;
                r_minor_down  <= n_minor_down;
                r_swapped     <= n_swapped;
                r_color       <= n_color;
            end
            if (i_line.ready) begin
                r_mid_vld <= i_line.valid;
            end
            if (out_adv) begin
                r_out_vld <= r_mid_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mid <= n_mid;
        end
        if (out_adv && r_mid_vld) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid        = r_out_vld;
    assign o_pix.pix_valid    = r_out.pix_valid;
    assign o_pix.pix_col      = r_out.col;
    assign o_pix.pix_row      = r_out.row;
    assign o_pix.pix_addr     = r_out.addr;
    assign o_pix.pix_value    = r_out.color;
    assign o_pix.last_pixel   = r_out.last;
    assign o_pix.out_of_frame = r_out.oof;

    // error term stays inside its Bresenham bounds while a line runs
    a_err_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_err <= $signed({2'b00, r_dmin, 1'b0}) &&
                           r_err >= -$signed({2'b00, r_dmaj, 1'b0})))
        else $error("error term out of bounds");

    // the major coordinate never passes the end of the line
    a_major_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_cur_major <= r_major_limit))
        else $error("major coordinate beyond line end");

    // a step with no line produces an empty pixel
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_line.cmd == lr_pkg::CMD_STEP && !r_line_active)
            |=> (r_mid_vld && !r_mid.pix_valid))
        else $error("step without a line produced a pixel");

    // an empty result carries only zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.pix_valid) |->
            (r_out.addr == '0 && !r_out.last && !r_out.oof && r_out.col == '0 &&
             r_out.row == '0 && r_out.color == '0))
        else $error("empty result carries data");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for line_rasterizer, with an in-bench Bresenham predictor.
// Depends on lr_pkg, the lr_* channel interfaces and the line_rasterizer RTL.
module tb_top;

    localparam int CW          = 12;
    localparam int PIPE_SETTLE = 6;        // slack after the queue drains, beyond the RTL pipeline
    localparam int RAND_ITEMS  = 60;       // minimum random commands per frame width
    localparam int LIMIT       = 200000;   // cycles before the run is declared hung
    localparam int N_PLAN      = 24;
    localparam logic [CW-1:0] CMAX = '1;

    typedef struct packed {
        logic                          cmd;
        logic [CW-1:0]                 xs;
        logic [CW-1:0]                 ys;
        logic [CW-1:0]                 xe;
        logic [CW-1:0]                 ye;
        logic [lr_pkg::COLOR_BITS-1:0] color;
    } t_line_cmd;

    typedef struct packed {
        logic                          pv;
        logic [CW-1:0]                 col;
        logic [CW-1:0]                 row;
        logic [lr_pkg::ADDR_BITS-1:0]  addr;
        logic [lr_pkg::COLOR_BITS-1:0] value;
        logic                          last;
        logic                          oof;
    } t_pixel;

    typedef struct packed {
        t_line_cmd c;
        logic      typed;   // 1: check against the pixel written here
        t_pixel    want;
    } t_plan_row;

    // Opening sequence at the reset width of 1024
    localparam t_plan_row OPENING_PLAN [0:N_PLAN-1] = '{
        // step with no line yet: invalid, all fields zero
        '{'{lr_pkg::CMD_STEP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF}, 1'b1,
          '{1'b0, 12'd0, 12'd0, 24'd0, 8'h00, 1'b0, 1'b0}},
        // single-point line at the origin
        '{'{lr_pkg::CMD_START, 12'd0, 12'd0, 12'd0, 12'd0, 8'hAA}, 1'b1,
          '{1'b1, 12'd0, 12'd0, 24'd0, 8'hAA, 1'b1, 1'b0}},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b1,
          '{1'b0, 12'd0, 12'd0, 24'd0, 8'h00, 1'b0, 1'b0}},
        // single point at the far corner, beyond the frame width
        '{'{lr_pkg::CMD_START, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'hFF}, 1'b1,
          '{1'b1, 12'd4095, 12'd4095, 24'd4197375, 8'hFF, 1'b1, 1'b1}},
        // full-width horizontal line, cut short by the next start
        '{'{lr_pkg::CMD_START, 12'd0, 12'd0, 12'd4095, 12'd0, 8'h55}, 1'b1,
          '{1'b1, 12'd0, 12'd0, 24'd0, 8'h55, 1'b0, 1'b0}},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        // shallow line given right to left; runs to its end and one past
        '{'{lr_pkg::CMD_START, 12'd10, 12'd20, 12'd3, 12'd25, 8'h01}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        // steep line, row is the major axis
        '{'{lr_pkg::CMD_START, 12'd5, 12'd100, 12'd8, 12'd90, 8'h80}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        // full diagonal with the minor axis stepping down
        '{'{lr_pkg::CMD_START, 12'd0, 12'd4095, 12'd4095, 12'd0, 8'h7F}, 1'b1,
          '{1'b1, 12'd0, 12'd4095, 24'd4193280, 8'h7F, 1'b0, 1'b0}},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        '{'{lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00}, 1'b0, '0},
        // steep line from the top right, column stepping down
        '{'{lr_pkg::CMD_START, 12'd4095, 12'd0, 12'd4094, 12'd4095, 8'h3C}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    lr_line_if #(.COORD_BITS(CW)) line_ch ();
    lr_pix_if  #(.COORD_BITS(CW)) pix_ch ();
    lr_cfg_if                     cfg_ch ();

    line_rasterizer #(.COORD_BITS(CW)) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_line  (line_ch.sink),
        .o_pix   (pix_ch.source)
    );

    // Predictor state, mirrors the block's line registers
    logic [CW-1:0]                   trace_major = '0;
    logic [CW-1:0]                   trace_minor = '0;
    logic [CW-1:0]                   trace_end   = '0;
    logic [CW-1:0]                   span_major  = '0;
    logic [CW-1:0]                   span_minor  = '0;
    int                              trace_err   = 0;
    logic                            minor_dec   = 1'b0;
    logic                            steep       = 1'b0;
    logic                            drawing     = 1'b0;
    logic [lr_pkg::COLOR_BITS-1:0]   ink         = '0;
    logic [lr_pkg::FRAME_W_BITS-1:0] stride      = lr_pkg::FRAME_W_RESET;

    t_pixel pending_pixels [$];
    t_pixel seen_px;
    t_pixel due_px;

    int  errors     = 0;
    int  cycles     = 0;
    int  n_sent     = 0;
    int  n_starts   = 0;
    int  n_pixels   = 0;
    int  n_last     = 0;
    int  n_oof      = 0;
    int  n_widths   = 1;
    bit  calm       = 1'b0;   // stretch with no idling on either side

    // Bresenham predictor: one command in, the pixel it produces out
    function automatic t_pixel trace_pixel(input t_line_cmd c);
        logic [CW-1:0] a1, b1, a2, b2, t, adx, ady;
        logic [31:0]   full;
        t_pixel        px;
        px = '0;
        if (c.cmd == lr_pkg::CMD_START) begin
            adx = (c.xs > c.xe) ? c.xs - c.xe : c.xe - c.xs;
            ady = (c.ys > c.ye) ? c.ys - c.ye : c.ye - c.ys;
            steep = (ady > adx);
            if (steep) begin
                a1 = c.ys; b1 = c.xs; a2 = c.ye; b2 = c.xe;
            end else begin
                a1 = c.xs; b1 = c.ys; a2 = c.xe; b2 = c.ye;
            end
            if (a1 > a2) begin
                t = a1; a1 = a2; a2 = t;
                t = b1; b1 = b2; b2 = t;
            end
            span_major  = a2 - a1;
            span_minor  = (b1 > b2) ? b1 - b2 : b2 - b1;
            minor_dec   = !(b1 < b2);
            trace_err   = 2 * int'(span_minor) - int'(span_major);
            trace_major = a1;
            trace_minor = b1;
            trace_end   = a2;
            ink         = c.color;
            drawing     = 1'b1;
        end else if (!drawing) begin
            return px;
        end
        // emit the current pixel
        px.pv    = 1'b1;
        px.col   = steep ? trace_minor : trace_major;
        px.row   = steep ? trace_major : trace_minor;
        full     = 32'(px.row) * 32'(stride) + 32'(px.col);
        px.addr  = full[lr_pkg::ADDR_BITS-1:0];
        px.value = ink;
        px.last  = (trace_major == trace_end);
        px.oof   = ({1'b0, px.col} >= stride);
        // advance, unless the line just ended
        if (px.last) begin
            drawing = 1'b0;
        end else begin
            if (trace_err < 0) begin
                trace_err += 2 * int'(span_minor);
            end else begin
                trace_err += 2 * int'(span_minor) - 2 * int'(span_major);
                trace_minor = minor_dec ? trace_minor - CW'(1) : trace_minor + CW'(1);
            end
            trace_major = trace_major + CW'(1);
        end
        return px;
    endfunction

    function automatic t_line_cmd rand_cmd(input logic cmd);
        t_line_cmd c;
        c.cmd   = cmd;
        c.xs    = CW'($urandom_range(0, 4095));
        c.ys    = CW'($urandom_range(0, 4095));
        c.xe    = CW'($urandom_range(0, 4095));
        c.ye    = CW'($urandom_range(0, 4095));
        c.color = lr_pkg::COLOR_BITS'($urandom_range(0, 255));
        return c;
    endfunction

    // endpoint within 15 of the given one, clamped to the coordinate range
    function automatic logic [CW-1:0] near(input logic [CW-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 30)) - 15;
        if (v < 0) v = 0;
        if (v > int'(CMAX)) v = int'(CMAX);
        return CW'(v);
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 3));
    endfunction

    // Drive one command, record its pixel on transfer, then idle for the gap given by the caller
    task automatic send_cmd(input t_line_cmd c, input logic typed, input t_pixel want,
                            input int gap);
        t_pixel px;
        @(negedge clk);
        line_ch.valid   <= 1'b1;
        line_ch.cmd     <= c.cmd;
        line_ch.x_start <= c.xs;
        line_ch.y_start <= c.ys;
        line_ch.x_end   <= c.xe;
        line_ch.y_end   <= c.ye;
        line_ch.color   <= c.color;
        do @(posedge clk); while (!line_ch.ready);
        px = trace_pixel(c);
        pending_pixels.push_back(typed ? want : px);
        n_sent++;
        if (c.cmd == lr_pkg::CMD_START) n_starts++;
        if (gap > 0) begin
            @(negedge clk) line_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Hold off until every pixel in flight has been returned
    task automatic settle();
        @(negedge clk) line_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_width(input logic [lr_pkg::FRAME_W_BITS-1:0] w);
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.frame_width <= w;
        do @(posedge clk); while (!cfg_ch.ready);
        stride = w;
        n_widths++;
        @(negedge clk) cfg_ch.valid <= 1'b0;
    endtask

    // Random traffic: mostly short lines run to completion, plus long lines
    // cut short by the next start and stray steps with no line
    task automatic run_random(input int n_items);
        int        first, kind, span, steps, seqs, dx, dy;
        t_line_cmd c;
        first = n_sent;
        seqs  = 0;
        while (n_sent - first < n_items) begin
            calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                steps = $urandom_range(1, 3);
            end else begin
                c = rand_cmd(lr_pkg::CMD_START);
                if (kind <= 7) begin
                    c.xe = near(c.xs);
                    c.ye = near(c.ys);
                end
                dx    = (c.xs > c.xe) ? int'(c.xs - c.xe) : int'(c.xe - c.xs);
                dy    = (c.ys > c.ye) ? int'(c.ys - c.ye) : int'(c.ye - c.ys);
                span  = (dx > dy) ? dx : dy;
                steps = (kind <= 7) ? span + int'($urandom_range(0, 2))
                                    : int'($urandom_range(0, 12));
                send_cmd(c, 1'b0, '0, draw_gap());
            end
            repeat (steps) send_cmd(rand_cmd(lr_pkg::CMD_STEP), 1'b0, '0, draw_gap());
            seqs++;
            // drain the pipe once mid-stream
            if (seqs == 4) settle();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result sink: random stall ahead of every result, none in calm stretches
    initial begin
        int stall;
        pix_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            stall = calm ? 0 : int'($urandom_range(0, 3));
            if (stall > 0) begin
                @(negedge clk) pix_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
                @(negedge clk) pix_ch.ready <= 1'b1;
            end else if (!pix_ch.ready) begin
                @(negedge clk) pix_ch.ready <= 1'b1;
            end
            do @(posedge clk); while (!pix_ch.valid);
        end
    end

    // Result checker: each transfer against the oldest pending pixel
    always @(posedge clk) begin
        if (rst_n && pix_ch.valid && pix_ch.ready) begin
            seen_px = '{pix_ch.pix_valid, pix_ch.pix_col, pix_ch.pix_row, pix_ch.pix_addr,
                        pix_ch.pix_value, pix_ch.last_pixel, pix_ch.out_of_frame};
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel result, expected none, got %h",
                         $time, seen_px);
                errors++;
            end else begin
                due_px = pending_pixels.pop_front();
                check_field("pix_valid",    32'(due_px.pv),    32'(seen_px.pv));
                check_field("pix_col",      32'(due_px.col),   32'(seen_px.col));
                check_field("pix_row",      32'(due_px.row),   32'(seen_px.row));
                check_field("pix_addr",     32'(due_px.addr),  32'(seen_px.addr));
                check_field("pix_value",    32'(due_px.value), 32'(seen_px.value));
                check_field("last_pixel",   32'(due_px.last),  32'(seen_px.last));
                check_field("out_of_frame", 32'(due_px.oof),   32'(seen_px.oof));
                if (seen_px.pv)   n_pixels++;
                if (seen_px.last) n_last++;
                if (seen_px.oof)  n_oof++;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("%0t: timeout with %0d pixels still pending", $time,
                     pending_pixels.size());
            $display("line_rasterizer: mismatch");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic [lr_pkg::FRAME_W_BITS-1:0] w;
        line_ch.valid      <= 1'b0;
        line_ch.cmd        <= lr_pkg::CMD_START;
        line_ch.x_start    <= '0;
        line_ch.y_start    <= '0;
        line_ch.x_end      <= '0;
        line_ch.y_end      <= '0;
        line_ch.color      <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.frame_width <= '0;
        rst_n              <= 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed opening at the reset width
        for (int i = 0; i < N_PLAN; i++) begin
            calm = 1'b0;
            send_cmd(OPENING_PLAN[i].c, OPENING_PLAN[i].typed, OPENING_PLAN[i].want,
                     draw_gap());
        end
        run_random(RAND_ITEMS);

        // narrowest, full, widest, zero and a random frame width
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: w = 13'd1;
                1: w = 13'd4096;
                2: w = 13'd8191;
                3: w = 13'd0;
                default: w = lr_pkg::FRAME_W_BITS'($urandom_range(1, 4096));
            endcase
            settle();
            write_width(w);
            run_random(RAND_ITEMS);
        end
        settle();

        $display("Sent %0d commands (%0d line starts) across %0d frame widths;",
                 n_sent, n_starts, n_widths);
        $display("checked %0d pixels, %0d line ends, %0d beyond the frame width.",
                 n_pixels, n_last, n_oof);
        if (errors == 0) begin
            $display("line_rasterizer: match");
        end else begin
            $display("line_rasterizer: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lr_pkg.sv
rtl/lr_ifs.sv
rtl/line_rasterizer.sv
tb/sv/tb_top.sv
